[hdl/page_frame_allocation_table_macros.svh]
// Assertion macros for the frame allocation table.
// Both expect clk and rst_n in scope at the point of use.
`ifndef PAGE_FRAME_ALLOCATION_TABLE_MACROS_SVH
`define PAGE_FRAME_ALLOCATION_TABLE_MACROS_SVH

// Consequent checked in the same cycle.
`define PFAT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PFAT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/pfat_pkg.sv]
// Shared sizes, codes and controller/datapath bundles for the frame allocation table.
// No dependencies.
package pfat_pkg;

    localparam int MAX_FRAMES    = 128;
    localparam int MAX_PROCESSES = 64;
    localparam int MAX_PAGES     = 64;
    localparam int TABLE_SIZE    = MAX_PROCESSES * MAX_PAGES;

    localparam int OP_W       = 2;
    localparam int PID_W      = 6;
    localparam int PAGE_W     = 6;
    localparam int FNO_W      = 7;
    localparam int PCOUNT_W   = 7;
    localparam int STATUS_W   = 3;
    localparam int FREE_OUT_W = 8;
    localparam int CFG_W      = 8;

    localparam int FRAME_AW = $clog2(MAX_FRAMES);
    localparam int FREE_W   = $clog2(MAX_FRAMES + 1);
    localparam int PROC_AW  = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int PAGE_AW  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int TBL_AW   = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int SWEEP_W  = (TBL_AW > FRAME_AW) ? TBL_AW : FRAME_AW;
    localparam int FC_RESET = (128 > MAX_FRAMES) ? MAX_FRAMES : 128;

    localparam logic [OP_W-1:0] OP_DECLARE  = 2'd0;
    localparam logic [OP_W-1:0] OP_ALLOCATE = 2'd1;
    localparam logic [OP_W-1:0] OP_RELEASE  = 2'd2;
    localparam logic [OP_W-1:0] OP_READ     = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FRAME_RANGE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FRAME_BUSY  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX   = 3'd4;

    typedef struct packed {
        logic clr_step;
        logic sweep_clr;
        logic rc_start;
        logic rc_step;
        logic accept;
        logic ent_rd;
        logic rel_step;
        logic finish;
    } pfat_cmd_t;

    typedef struct packed {
        logic            clr_last;
        logic            rc_last;
        logic            rc_pending;
        logic            bad_pid;
        logic [OP_W-1:0] op;
        logic            decl_big;
        logic            page_bad;
        logic            cursor_last;
        logic            out_free;
    } pfat_stat_t;

endpackage

[hdl/pfat_if.sv]
// Request and result channel interfaces of the frame allocation table.
// Depends on pfat_pkg for field widths.
interface pfat_req_if;
    import pfat_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [PID_W-1:0]    process_id;
    logic [PAGE_W-1:0]   page_index;
    logic [FNO_W-1:0]    frame_no;
    logic [PCOUNT_W-1:0] page_count;

    modport source (output valid, op, process_id, page_index, frame_no, page_count,
                    input ready);
    modport sink   (input valid, op, process_id, page_index, frame_no, page_count,
                    output ready);
endinterface

interface pfat_rsp_if;
    import pfat_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic [FREE_OUT_W-1:0] free_count;
    logic                  enough_free;
    logic [FNO_W-1:0]      mapped_frame;
    logic                  mapped;

    modport source (output valid, status, free_count, enough_free, mapped_frame, mapped,
                    input ready);
    modport sink   (input valid, status, free_count, enough_free, mapped_frame, mapped,
                    output ready);
endinterface

[hdl/pfat_ctrl.sv]
// Sequencer of the frame allocation table: clear pass, recount, request steps.
// Depends on pfat_pkg for the command and status bundles.
module pfat_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  pfat_pkg::pfat_stat_t stat,
    output pfat_pkg::pfat_cmd_t  cmd
);
    import pfat_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RECOUNT,
        S_DECIDE,
        S_REL,
        S_DRAIN,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    cmd.sweep_clr = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (stat.rc_pending)
                begin
                    cmd.rc_start = 1'b1;
                    state_next   = S_RECOUNT;
                end
                else
                begin
                    // hold off a request that collides with a register write
                    in_ready = !cfg_we;
                    if (in_valid && !cfg_we)
                    begin
                        cmd.accept = 1'b1;
                        state_next = S_DECIDE;
                    end
                end
            end
            S_RECOUNT:
            begin
                cmd.rc_step = 1'b1;
                if (stat.rc_last)
                begin
                    cmd.sweep_clr = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_DECIDE:
            begin
                priority if (stat.bad_pid)
                begin
                    state_next = S_FINISH;
                end
                else if (stat.op == OP_DECLARE && stat.decl_big)
                begin
                    state_next = S_FINISH;
                end
                else if (stat.op == OP_DECLARE || stat.op == OP_RELEASE)
                begin
                    state_next = S_REL;
                end
                else if (stat.page_bad)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.ent_rd = 1'b1;
                    state_next = S_FINISH;
                end
            end
            S_REL:
            begin
                cmd.rel_step = 1'b1;
                if (stat.cursor_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[hdl/pfat_dp.sv]
// Datapath of the frame allocation table: used bits, free count, page table memory,
// page count memory, release walk and result register. Depends on pfat_pkg.
module pfat_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [pfat_pkg::CFG_W-1:0]      cfg_data,
    input  logic [pfat_pkg::OP_W-1:0]       in_op,
    input  logic [pfat_pkg::PID_W-1:0]      in_process_id,
    input  logic [pfat_pkg::PAGE_W-1:0]     in_page_index,
    input  logic [pfat_pkg::FNO_W-1:0]      in_frame_no,
    input  logic [pfat_pkg::PCOUNT_W-1:0]   in_page_count,
    input  pfat_pkg::pfat_cmd_t             cmd,
    output pfat_pkg::pfat_stat_t            stat,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic [pfat_pkg::STATUS_W-1:0]   out_status,
    output logic [pfat_pkg::FREE_OUT_W-1:0] out_free_count,
    output logic                            out_enough_free,
    output logic [pfat_pkg::FNO_W-1:0]      out_mapped_frame,
    output logic                            out_mapped
);
    import pfat_pkg::*;

    // page table: valid bit on top of the frame number
    logic [FNO_W:0]          pt_mem [TABLE_SIZE];
    logic [PCOUNT_W-1:0]     pp_mem [MAX_PROCESSES];

    logic [CFG_W-1:0]        fc_reg;
    logic                    pending_reg;
    logic [FREE_W-1:0]       free_reg;
    logic [MAX_FRAMES-1:0]   used_reg;
    logic [SWEEP_W-1:0]      sweep_reg;
    logic [PAGE_AW-1:0]      cursor_reg;
    logic                    pend_reg;
    logic [TBL_AW-1:0]       pend_addr_reg;
    logic [FNO_W:0]          rd_entry_reg;
    logic [PCOUNT_W-1:0]     pp_rd_reg;

    logic [OP_W-1:0]         op_reg;
    logic [PID_W-1:0]        pid_reg;
    logic [PAGE_W-1:0]       page_reg;
    logic [FNO_W-1:0]        fno_reg;
    logic [PCOUNT_W-1:0]     pcount_reg;

    logic                    res_valid_reg;
    logic [STATUS_W-1:0]     res_status_reg;
    logic [FREE_OUT_W-1:0]   res_free_reg;
    logic                    res_enough_reg;
    logic [FNO_W-1:0]        res_frame_reg;
    logic                    res_mapped_reg;

    logic [PROC_AW-1:0]      pid_idx;
    logic [TBL_AW-1:0]       tbl_base;
    logic [TBL_AW-1:0]       item_addr;
    logic [TBL_AW-1:0]       rel_addr;
    logic                    bad_pid;
    logic                    decl_big;
    logic                    page_bad;

    logic                    ent_valid;
    logic [FNO_W-1:0]        ent_frame;
    logic [FRAME_AW-1:0]     old_idx;
    logic                    old_hit;
    logic                    old_counts;
    logic [FRAME_AW-1:0]     new_idx;
    logic                    new_used;
    logic [MAX_FRAMES-1:0]   old_mask;
    logic [MAX_FRAMES-1:0]   new_mask;
    logic [FRAME_AW-1:0]     sweep_idx;
    logic                    sweep_counts;

    logic [STATUS_W-1:0]     alloc_status;
    logic [STATUS_W-1:0]     status_c;
    logic [FNO_W-1:0]        frame_c;
    logic                    mapped_c;
    logic                    alloc_ok;
    logic                    decl_ok;
    logic [PCOUNT_W-1:0]     pp_after;
    logic [FREE_W-1:0]       free_after;
    logic                    enough_c;

    logic                    pt_we;
    logic [TBL_AW-1:0]       pt_waddr;
    logic [FNO_W:0]          pt_wdata;
    logic                    pt_re;
    logic [TBL_AW-1:0]       pt_raddr;
    logic                    pp_we;
    logic [PROC_AW-1:0]      pp_waddr;
    logic [PCOUNT_W-1:0]     pp_wdata;

    // decode of the held request
    assign pid_idx   = PROC_AW'(pid_reg);
    assign tbl_base  = TBL_AW'(pid_idx) * TBL_AW'(MAX_PAGES);
    assign item_addr = tbl_base + TBL_AW'(page_reg);
    assign rel_addr  = tbl_base + TBL_AW'(cursor_reg);
    assign bad_pid   = !(int'(pid_reg) < MAX_PROCESSES);
    assign decl_big  = (int'(pcount_reg) > int'(fc_reg)) || (int'(pcount_reg) > MAX_PAGES);
    assign page_bad  = int'(page_reg) >= int'(pp_rd_reg);

    // frame held by the entry just read, and whether freeing it adds a free frame
    assign ent_valid  = rd_entry_reg[FNO_W];
    assign ent_frame  = rd_entry_reg[FNO_W-1:0];
    assign old_idx    = FRAME_AW'(ent_frame);
    assign old_hit    = ent_valid && (int'(ent_frame) < MAX_FRAMES) && used_reg[old_idx];
    assign old_counts = old_hit && (int'(ent_frame) < int'(fc_reg));

    assign new_idx  = FRAME_AW'(fno_reg);
    assign new_used = (int'(fno_reg) < MAX_FRAMES) && used_reg[new_idx];

    assign old_mask = old_hit ? (MAX_FRAMES'(1) << old_idx) : '0;
    assign new_mask = MAX_FRAMES'(1) << new_idx;

    assign sweep_idx    = FRAME_AW'(sweep_reg);
    assign sweep_counts = (int'(sweep_reg) < int'(fc_reg)) && !used_reg[sweep_idx];

    always_comb
    begin
        priority if (int'(pp_rd_reg) > int'(fc_reg))
        begin
            alloc_status = ST_TOO_LARGE;
        end
        else if ((int'(fno_reg) >= int'(fc_reg)) || (int'(fno_reg) >= MAX_FRAMES))
        begin
            alloc_status = ST_FRAME_RANGE;
        end
        else if (new_used)
        begin
            alloc_status = ST_FRAME_BUSY;
        end
        else
        begin
            alloc_status = ST_OK;
        end
    end

    // result and commit decisions, valid in the finish step
    always_comb
    begin
        status_c   = ST_OK;
        frame_c    = '0;
        mapped_c   = 1'b0;
        alloc_ok   = 1'b0;
        decl_ok    = 1'b0;
        pp_after   = pp_rd_reg;
        free_after = free_reg;
        priority if (bad_pid)
        begin
            status_c = ST_BAD_INDEX;
        end
        else if (op_reg == OP_DECLARE)
        begin
            if (decl_big)
            begin
                status_c = ST_TOO_LARGE;
            end
            else
            begin
                decl_ok  = 1'b1;
                pp_after = pcount_reg;
            end
        end
        else if (op_reg == OP_RELEASE)
        begin
            status_c = ST_OK;
        end
        else if (page_bad)
        begin
            status_c = ST_BAD_INDEX;
        end
        else
        begin
            if (op_reg == OP_ALLOCATE)
            begin
                status_c = alloc_status;
            end
            if (op_reg == OP_ALLOCATE && alloc_status == ST_OK)
            begin
                alloc_ok   = 1'b1;
                free_after = free_reg + FREE_W'(old_counts) - FREE_W'(1);
                mapped_c   = 1'b1;
                frame_c    = fno_reg;
            end
            else if (ent_valid)
            begin
                mapped_c = 1'b1;
                frame_c  = ent_frame;
            end
        end
        enough_c = !bad_pid && (free_after != '0) && (int'(free_after) >= int'(pp_after));
    end

    // page table port: clear pass, release invalidation, allocate, and the entry read
    always_comb
    begin
        pt_we    = 1'b0;
        pt_waddr = item_addr;
        pt_wdata = '0;
        priority if (cmd.clr_step)
        begin
            pt_we    = 1'b1;
            pt_waddr = TBL_AW'(sweep_reg);
        end
        else if (pend_reg && ent_valid)
        begin
            pt_we    = 1'b1;
            pt_waddr = pend_addr_reg;
        end
        else if (cmd.finish && alloc_ok)
        begin
            pt_we    = 1'b1;
            pt_wdata = {1'b1, fno_reg};
        end
        pt_re    = cmd.ent_rd || cmd.rel_step;
        pt_raddr = cmd.rel_step ? rel_addr : item_addr;
    end

    always_comb
    begin
        pp_we    = 1'b0;
        pp_waddr = pid_idx;
        pp_wdata = pcount_reg;
        priority if (cmd.clr_step)
        begin
            pp_we    = int'(sweep_reg) < MAX_PROCESSES;
            pp_waddr = PROC_AW'(sweep_reg);
            pp_wdata = '0;
        end
        else if (cmd.finish && decl_ok)
        begin
            pp_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pt_we)
        begin
            pt_mem[pt_waddr] <= pt_wdata;
        end
        if (pt_re)
        begin
            rd_entry_reg <= pt_mem[pt_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pp_we)
        begin
            pp_mem[pp_waddr] <= pp_wdata;
        end
        if (cmd.accept)
        begin
            pp_rd_reg <= pp_mem[PROC_AW'(in_process_id)];
        end
    end

    // held request and release pipeline address
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg     <= in_op;
            pid_reg    <= in_process_id;
            page_reg   <= in_page_index;
            fno_reg    <= in_frame_no;
            pcount_reg <= in_page_count;
        end
        pend_addr_reg <= rel_addr;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            res_status_reg <= status_c;
            res_free_reg   <= FREE_OUT_W'(free_after);
            res_enough_reg <= enough_c;
            res_frame_reg  <= frame_c;
            res_mapped_reg <= mapped_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fc_reg        <= CFG_W'(FC_RESET);
            pending_reg   <= 1'b0;
            free_reg      <= FREE_W'(FC_RESET);
            used_reg      <= '0;
            sweep_reg     <= '0;
            cursor_reg    <= '0;
            pend_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                fc_reg <= (int'(cfg_data) > MAX_FRAMES) ? CFG_W'(MAX_FRAMES) : cfg_data;
            end

            if (cfg_we)
            begin
                pending_reg <= 1'b1;
            end
            else if (cmd.rc_start)
            begin
                pending_reg <= 1'b0;
            end

            priority if (cmd.rc_start)
            begin
                free_reg <= '0;
            end
            else if (cmd.rc_step)
            begin
                free_reg <= free_reg + FREE_W'(sweep_counts);
            end
            else if (pend_reg)
            begin
                free_reg <= free_reg + FREE_W'(old_counts);
            end
            else if (cmd.finish && alloc_ok)
            begin
                free_reg <= free_after;
            end

            // the new frame is free, so it never equals the old one being dropped
            if (pend_reg && old_hit)
            begin
                used_reg[old_idx] <= 1'b0;
            end
            else if (cmd.finish && alloc_ok)
            begin
                used_reg <= (used_reg & ~old_mask) | new_mask;
            end

            priority if (cmd.sweep_clr)
            begin
                sweep_reg <= '0;
            end
            else if (cmd.clr_step || cmd.rc_step)
            begin
                sweep_reg <= sweep_reg + SWEEP_W'(1);
            end

            if (cmd.rel_step)
            begin
                cursor_reg <= stat.cursor_last ? '0 : cursor_reg + PAGE_AW'(1);
            end
            pend_reg <= cmd.rel_step;

            if (cmd.finish)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        stat.clr_last    = sweep_reg == SWEEP_W'(TABLE_SIZE - 1);
        stat.rc_last     = sweep_reg == SWEEP_W'(MAX_FRAMES - 1);
        stat.rc_pending  = pending_reg;
        stat.bad_pid     = bad_pid;
        stat.op          = op_reg;
        stat.decl_big    = decl_big;
        stat.page_bad    = page_bad;
        stat.cursor_last = cursor_reg == PAGE_AW'(MAX_PAGES - 1);
        stat.out_free    = !res_valid_reg || out_ready;
    end

    assign out_valid        = res_valid_reg;
    assign out_status       = res_status_reg;
    assign out_free_count   = res_free_reg;
    assign out_enough_free  = res_enough_reg;
    assign out_mapped_frame = res_frame_reg;
    assign out_mapped       = res_mapped_reg;

endmodule

[hdl/page_frame_allocation_table.sv]
// Frame allocation table, top level. Allocate and read pass a decide step that reads the
// page entry and a finish step that loads the result register. Declare and release walk
// every page entry of the process through one memory port. One request is in work at a
// time; a result may wait in the output register while the next request enters. After
// reset a clearing pass over all TABLE_SIZE entries (4096) runs before the first request;
// a frame_count write recounts free frames over MAX_FRAMES (128) with requests held off.
`include "page_frame_allocation_table_macros.svh"

module page_frame_allocation_table (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [pfat_pkg::CFG_W-1:0] cfg_data,
    pfat_req_if.sink                   req,
    pfat_rsp_if.source                 rsp
);
    import pfat_pkg::*;

    pfat_cmd_t  cmd;
    pfat_stat_t stat;
    logic       in_ready;

    pfat_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pfat_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_data         (cfg_data),
        .in_op            (req.op),
        .in_process_id    (req.process_id),
        .in_page_index    (req.page_index),
        .in_frame_no      (req.frame_no),
        .in_page_count    (req.page_count),
        .cmd              (cmd),
        .stat             (stat),
        .out_ready        (rsp.ready),
        .out_valid        (rsp.valid),
        .out_status       (rsp.status),
        .out_free_count   (rsp.free_count),
        .out_enough_free  (rsp.enough_free),
        .out_mapped_frame (rsp.mapped_frame),
        .out_mapped       (rsp.mapped)
    );

    assign req.ready = in_ready;

    `PFAT_ASSERT_NEXT(a_busy_after_request, req.valid && req.ready, !req.ready, "request taken while busy")
    `PFAT_ASSERT_NEXT(a_cfg_holds_requests, cfg_we, !req.ready, "request open during recount")
    `PFAT_ASSERT_SAME(a_result_from_finish, $rose(rsp.valid), $past(cmd.finish), "result without finish")
    `PFAT_ASSERT_SAME(a_finish_has_room, cmd.finish, !rsp.valid || rsp.ready, "result overwritten")

endmodule

[bench/frame_table_checker.sv]
// Checker for the frame allocation table: watches the request, result and register ports,
// keeps its own copy of the frame and page tables and compares every result.
// Depends on pfat_pkg and the channel interfaces in pfat_if.sv.
`timescale 1ns / 1ps

module frame_table_checker
    import pfat_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_data,
    pfat_req_if              req,
    pfat_rsp_if              rsp,
    output int               errors,
    output int               pending,
    output int               checked
);

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [FREE_OUT_W-1:0] free_count;
        logic                  enough_free;
        logic [FNO_W-1:0]      mapped_frame;
        logic                  mapped;
    } table_reply_t;

    logic             used_bits  [MAX_FRAMES];
    logic [FNO_W-1:0] slot_frame [TABLE_SIZE];
    logic             slot_valid [TABLE_SIZE];
    int               proc_pages [MAX_PROCESSES];
    int               free_total;
    int               frame_limit;

    table_reply_t expected_replies [$];
    table_reply_t want;
    table_reply_t got;

    function automatic void recount_free();
        int n;
        n = 0;
        for (int i = 0; i < frame_limit; i++)
        begin
            if (!used_bits[i])
                n++;
        end
        free_total = n;
    endfunction

    function automatic void drop_frame(int f);
        if (used_bits[f])
        begin
            used_bits[f] = 1'b0;
            // frames beyond a shrunk limit are not counted as free
            if (f < frame_limit)
                free_total++;
        end
    endfunction

    function automatic void release_pages(int pid);
        int idx;
        for (int p = 0; p < MAX_PAGES; p++)
        begin
            idx = pid * MAX_PAGES + p;
            if (slot_valid[idx])
            begin
                drop_frame(int'(slot_frame[idx]));
                slot_valid[idx] = 1'b0;
            end
        end
    endfunction

    function automatic table_reply_t apply_request(logic [OP_W-1:0] op, int pid, int page,
                                                   int fno, int pc);
        table_reply_t r;
        int           idx;
        r   = '0;
        idx = pid * MAX_PAGES + page;
        if (op == OP_DECLARE)
        begin
            if (pc > frame_limit || pc > MAX_PAGES)
                r.status = ST_TOO_LARGE;
            else
            begin
                release_pages(pid);
                proc_pages[pid] = pc;
            end
        end
        else if (op == OP_RELEASE)
            release_pages(pid);
        else if (page >= proc_pages[pid])
            r.status = ST_BAD_INDEX;
        else
        begin
            if (op == OP_ALLOCATE)
            begin
                if (proc_pages[pid] > frame_limit)
                    r.status = ST_TOO_LARGE;
                else if (fno >= frame_limit)
                    r.status = ST_FRAME_RANGE;
                else if (used_bits[fno])
                    r.status = ST_FRAME_BUSY;
                else
                begin
                    // free the old frame only once the new one is known good
                    if (slot_valid[idx])
                        drop_frame(int'(slot_frame[idx]));
                    used_bits[fno]  = 1'b1;
                    free_total--;
                    slot_frame[idx] = fno[FNO_W-1:0];
                    slot_valid[idx] = 1'b1;
                end
            end
            if (slot_valid[idx])
            begin
                r.mapped       = 1'b1;
                r.mapped_frame = slot_frame[idx];
            end
        end
        r.free_count  = free_total[FREE_OUT_W-1:0];
        r.enough_free = (free_total != 0 && free_total >= proc_pages[pid]);
        return r;
    endfunction

    function automatic void clear_tables();
        foreach (used_bits[i])
            used_bits[i] = 1'b0;
        foreach (slot_valid[i])
        begin
            slot_valid[i] = 1'b0;
            slot_frame[i] = '0;
        end
        foreach (proc_pages[i])
            proc_pages[i] = 0;
        frame_limit = FC_RESET;
        recount_free();
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_tables();
            expected_replies.delete();
            errors  = 0;
            pending = 0;
            checked = 0;
        end
        else
        begin
            // compare before predicting: a result never belongs to a request of the same edge
            if (rsp.valid && rsp.ready)
            begin
                got = {rsp.status, rsp.free_count, rsp.enough_free, rsp.mapped_frame,
                       rsp.mapped};
                checked++;
                if (expected_replies.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected nothing,",
                             $time,
                             " actual status %0d free %0d enough %0b frame %0d mapped %0b",
                             got.status, got.free_count, got.enough_free,
                             got.mapped_frame, got.mapped);
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (got.status !== want.status || got.free_count !== want.free_count
                        || got.enough_free !== want.enough_free
                        || got.mapped_frame !== want.mapped_frame || got.mapped !== want.mapped)
                    begin
                        errors++;
                        $display("%0t: mismatch expected status %0d free %0d enough %0b",
                                 $time, want.status, want.free_count, want.enough_free,
                                 " frame %0d mapped %0b,", want.mapped_frame, want.mapped,
                                 " actual status %0d free %0d enough %0b",
                                 got.status, got.free_count, got.enough_free,
                                 " frame %0d mapped %0b", got.mapped_frame, got.mapped);
                    end
                end
            end
            if (cfg_we)
            begin
                frame_limit = (cfg_data > MAX_FRAMES) ? MAX_FRAMES : int'(cfg_data);
                recount_free();
            end
            if (req.valid && req.ready)
                expected_replies.push_back(apply_request(req.op, int'(req.process_id),
                                                         int'(req.page_index),
                                                         int'(req.frame_no),
                                                         int'(req.page_count)));
            pending = expected_replies.size();
        end
    end

endmodule

[bench/testbench.sv]
// Top of the frame allocation table bench: clock, reset, request and register stimulus,
// random result stalls and the verdict. Depends on pfat_pkg, pfat_if.sv and frame_table_checker.
`timescale 1ns / 1ps

module testbench;
    import pfat_pkg::*;

    localparam int HALF_PERIOD    = 5;
    localparam int LIMIT_CYCLES   = 750_000;
    localparam int PHASE_REQUESTS = 120;
    localparam int SETTLE_CYCLES  = 80;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_data;

    int errors;
    int pending;
    int checked;
    int cycles     = 0;
    int sent       = 0;
    int writes     = 0;
    int stall_left = 0;
    int fc_now;
    bit quiet;
    int decl_pages [MAX_PROCESSES];

    logic [CFG_W-1:0] fc_plan [9] = '{8'd128, 8'd1, 8'd16, 8'd200, 8'd2, 8'd64, 8'd255,
                                      8'd37, 8'd128};

    pfat_req_if req_ch();
    pfat_rsp_if rsp_ch();

    page_frame_allocation_table i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .req      (req_ch),
        .rsp      (rsp_ch)
    );

    frame_table_checker i_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .req      (req_ch),
        .rsp      (rsp_ch),
        .errors   (errors),
        .pending  (pending),
        .checked  (checked)
    );

    initial clk = 1'b0;
    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles with %0d results outstanding", cycles, pending);
            $display("status: fail");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            rsp_ch.ready <= 1'b1;
            if (!quiet)
                stall_left = pick_gap();
        end
    end

    task automatic send_request(logic [OP_W-1:0] op, int pid, int page, int fno, int pc);
        int gap;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_ch.valid      <= 1'b1;
        req_ch.op         <= op;
        req_ch.process_id <= pid[PID_W-1:0];
        req_ch.page_index <= page[PAGE_W-1:0];
        req_ch.frame_no   <= fno[FNO_W-1:0];
        req_ch.page_count <= pc[PCOUNT_W-1:0];
        do
            @(posedge clk);
        while (!req_ch.ready);
        sent++;
        // remember page counts so later requests mostly hit declared pages
        if (op == OP_DECLARE && pc <= fc_now && pc <= MAX_PAGES)
            decl_pages[pid] = pc;
    endtask

    task automatic send_random();
        int pick;
        int r;
        int pid;
        int page;
        int fno;
        int pc;
        pick = $urandom_range(0, 99);
        pid  = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 7)
                                          : $urandom_range(0, MAX_PROCESSES - 1);
        if (decl_pages[pid] > 0 && $urandom_range(0, 99) < 85)
            page = $urandom_range(0, decl_pages[pid] - 1);
        else
            page = $urandom_range(0, MAX_PAGES - 1);
        fno = ($urandom_range(0, 99) < 85) ? $urandom_range(0, fc_now - 1)
                                           : $urandom_range(0, MAX_FRAMES - 1);
        r = $urandom_range(0, 99);
        if (r < 70)
            pc = $urandom_range(0, (fc_now < 12) ? fc_now : 12);
        else if (r < 90)
            pc = $urandom_range(0, MAX_PAGES);
        else
            pc = $urandom_range(0, 127);
        if (pick < 10)
            send_request(OP_DECLARE, pid, page, fno, pc);
        else if (pick < 58)
            send_request(OP_ALLOCATE, pid, page, fno, pc);
        else if (pick < 66)
            send_request(OP_RELEASE, pid, page, fno, pc);
        else if (pick < 93)
            send_request(OP_READ, pid, page, fno, pc);
        else
            send_request(OP_W'($urandom_range(0, 3)), $urandom_range(0, 63),
                         $urandom_range(0, 63), $urandom_range(0, 127),
                         $urandom_range(0, 127));
    endtask

    // drop valid, wait for every result, then let the table settle
    task automatic drain();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_frame_count(logic [CFG_W-1:0] v);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we   <= 1'b0;
        fc_now = (v > MAX_FRAMES) ? MAX_FRAMES : int'(v);
        writes++;
    endtask

    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_data          = '0;
        req_ch.valid      = 1'b0;
        req_ch.op         = OP_DECLARE;
        req_ch.process_id = '0;
        req_ch.page_index = '0;
        req_ch.frame_no   = '0;
        req_ch.page_count = '0;
        rsp_ch.ready      = 1'b0;
        quiet             = 1'b0;
        fc_now            = FC_RESET;
        foreach (decl_pages[i])
            decl_pages[i] = 0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // directed part at the reset frame count
        send_request(OP_READ,     0,  0,   0,   0);
        send_request(OP_DECLARE,  0,  0,   0,  64);
        send_request(OP_DECLARE, 63,  0,   0,  65);
        send_request(OP_DECLARE, 63,  0,   0, 127);
        send_request(OP_DECLARE, 63,  0,   0,   0);
        send_request(OP_ALLOCATE, 0,  0,   0,   0);
        send_request(OP_ALLOCATE, 0, 63, 127,   0);
        send_request(OP_ALLOCATE, 1,  0,   5,   0);
        send_request(OP_ALLOCATE, 0,  1,   0,   0);
        send_request(OP_READ,     0,  0,   0,   0);
        send_request(OP_READ,     0,  1,   0,   0);
        send_request(OP_ALLOCATE, 0,  0,  10,   0);
        send_request(OP_ALLOCATE, 0,  2,   0,   0);
        send_request(OP_DECLARE,  2,  0,   0,   3);
        send_request(OP_ALLOCATE, 2,  2,   1,   0);
        send_request(OP_DECLARE,  0, 63, 127,   5);
        send_request(OP_READ,     0,  0,   0,   0);
        send_request(OP_RELEASE,  2,  0,   0,   0);
        send_request(OP_RELEASE,  2,  0,   0,   0);
        send_request(OP_RELEASE,  5, 63, 127, 127);
        send_request(OP_READ,     0,  5,   0,   0);
        send_request(OP_READ,    63, 63, 127, 127);

        foreach (fc_plan[k])
        begin
            write_frame_count(fc_plan[k]);
            repeat (PHASE_REQUESTS)
            begin
                // every fifth stretch of fifty requests runs without gaps or stalls
                quiet = ((sent / 50) % 5 == 4);
                send_random();
            end
        end
        quiet = 1'b0;
        drain();

        $display("covered %0d requests and %0d compared results over %0d frame-count writes",
                 sent, checked, writes);
        if (errors == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
